// File: rtl/hhdp_pkg.sv
// Shared types and constants for the heading-hold drive profile block.
`timescale 1ns / 1ps

package hhdp_pkg;

    // field and register widths
    localparam int TD_W       = 17;
    localparam int TH_W       = 16;
    localparam int SPD_W      = 7;
    localparam int GAIN_W     = 10;
    localparam int RAMP_W     = 17;
    localparam int BM_W       = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;
    localparam int HEAD_W     = 16;
    localparam int ENC_W      = 24;
    localparam int VEL_W      = 11;

    // internal datapath widths
    localparam int DL_W    = 26;
    localparam int TRAV_W  = DL_W + 1;
    localparam int ERR_W   = 12;
    localparam int DIFF_W  = 18;
    localparam int S_W     = 11;
    localparam int GE_W    = 22;
    localparam int FAC_W   = 23;
    localparam int MUL_A_W = 25;
    localparam int MUL_B_W = 23;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int PROD_W  = 37;

    // shared divider
    localparam int DIV_NUM_W = 28;
    localparam int DIV_DEN_W = 17;
    localparam int DIV_Q_W   = 11;
    localparam int DIV_STEPS = DIV_Q_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    // arithmetic constants
    localparam logic signed [DIFF_W-1:0] ERR_WRAP_LIMIT = 18'sd27000;
    localparam logic signed [DIFF_W-1:0] FULL_TURN      = 18'sd36000;
    localparam logic signed [DIFF_W-1:0] ERR_CLAMP      = 18'sd1500;
    localparam logic signed [FAC_W-1:0]  GAIN_SCALE     = 23'sd100000;
    localparam logic [DIV_DEN_W-1:0]     GAIN_SCALE_DEN = 17'd100000;
    localparam logic [PROD_W-1:0]        VEL_SAT_LIMIT  = 37'd100100000;
    localparam logic [S_W-1:0]           VEL_LIMIT      = 11'd1000;
    localparam logic signed [VEL_W-1:0]  VEL_MAX        = 11'sd1000;
    localparam logic [MUL_B_W-1:0]       DIST_Q10       = 23'd3574;
    localparam int                       DIST_SHIFT     = 10;
    localparam logic [S_W-1:0]           SPEED_SCALE    = 11'd10;

    // command codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    // stop modes
    localparam logic [BM_W-1:0] BRAKE_COAST = 2'd0;
    localparam logic [BM_W-1:0] BRAKE_BRAKE = 2'd1;
    localparam logic [BM_W-1:0] BRAKE_HOLD  = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_DISTANCE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_HEADING  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CRUISE_SPEED    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEER_GAIN      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REVERSE         = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FINAL_SPEED     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_LENGTH     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_BRAKE_MODE      = 3'd7;

    // register reset values
    localparam logic [TD_W-1:0]   TD_RST   = 17'd0;
    localparam logic [TH_W-1:0]   TH_RST   = 16'd0;
    localparam logic [SPD_W-1:0]  CS_RST   = 7'd50;
    localparam logic [GAIN_W-1:0] GAIN_RST = 10'd20;
    localparam logic              REV_RST  = 1'b0;
    localparam logic [SPD_W-1:0]  FS_RST   = 7'd20;
    localparam logic [RAMP_W-1:0] RAMP_RST = 17'd1000;
    localparam logic [BM_W-1:0]   BM_RST   = BRAKE_BRAKE;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_SPD_GO,
        S_SPD_WAIT,
        S_VA_MUL,
        S_VA_GO,
        S_VA_WAIT,
        S_VB_GO,
        S_VB_WAIT,
        S_DONE
    } state_t;

endpackage

// File: rtl/hhdp_div.sv
// Restoring divider, one quotient bit per cycle, shared by the speed and velocity steps.
`timescale 1ns / 1ps

module hhdp_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [hhdp_pkg::DIV_NUM_W-1:0]  num,
    input  logic [hhdp_pkg::DIV_DEN_W-1:0]  den,
    output logic                            done,
    output logic [hhdp_pkg::DIV_Q_W-1:0]    quot
);
    import hhdp_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_NUM_W-1:0] rem_reg, rem_next;
    logic [DIV_NUM_W-1:0] dvs_reg, dvs_next;
    logic [DIV_Q_W-1:0]   q_reg, q_next;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        q_next    = q_reg;
        priority if (start)
        begin
            rem_next  = num;
            dvs_next  = DIV_NUM_W'(den) << (DIV_STEPS - 1);
            q_next    = '0;
            cnt_next  = DIV_CNT_W'(DIV_STEPS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_reg >= dvs_reg)
            begin
                rem_next = rem_reg - dvs_reg;
                q_next   = {q_reg[DIV_Q_W-2:0], 1'b1};
            end
            else
            begin
                q_next = {q_reg[DIV_Q_W-2:0], 1'b0};
            end
            dvs_next = dvs_reg >> 1;
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

// File: rtl/heading_hold_drive_profile.sv
// Top level: heading-hold straight drive with ramped speed profile.
//
//   port group   dir   handshake              contents
//   cfg          in    cfg_write              cfg_index, cfg_data
//   in           in    in_valid / in_ready    command, heading_cdeg, encoder_deg
//   out          out   out_valid / out_ready  velocities, spin_reverse, done_res, stop_mode
//
// Start beat or tick while idle: result valid and in_ready come back together from S_DONE.
// Tick while moving: result valid and in_ready come back after three passes of the
// 11-step shared divider (speed ramp, then each side's velocity) and the sequencer steps.
// rst_n clears state, registers to their defaults and the output valid.
// A finished result sits in the output register; a new beat is taken while it waits, and a
// second finished result holds until out_ready frees the register.
`timescale 1ns / 1ps

module heading_hold_drive_profile (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_write,
    input  logic [hhdp_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [hhdp_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic                                   command,
    input  logic [hhdp_pkg::HEAD_W-1:0]            heading_cdeg,
    input  logic signed [hhdp_pkg::ENC_W-1:0]      encoder_deg,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [hhdp_pkg::VEL_W-1:0]      left_velocity,
    output logic signed [hhdp_pkg::VEL_W-1:0]      right_velocity,
    output logic                                   spin_reverse,
    output logic                                   done_res,
    output logic [hhdp_pkg::BM_W-1:0]              stop_mode
);
    import hhdp_pkg::*;

    // configuration
    logic [TD_W-1:0]   td_reg;
    logic [TH_W-1:0]   th_reg;
    logic [SPD_W-1:0]  cs_reg;
    logic [GAIN_W-1:0] gain_reg;
    logic              rev_reg;
    logic [SPD_W-1:0]  fs_reg;
    logic [RAMP_W-1:0] ramp_reg;
    logic [BM_W-1:0]   bm_reg;

    state_t state_reg, state_next;

    logic                    moving_reg, moving_next;
    logic signed [DL_W-1:0]  dl_reg, dl_next;
    logic [HEAD_W-1:0]       heading_reg, heading_next;
    logic [ENC_W-1:0]        mag_reg, mag_next;
    logic signed [ERR_W-1:0] err_reg, err_next;
    logic                    direct_reg, direct_next;
    logic [S_W-1:0]          s_reg, s_next;
    logic signed [GE_W-1:0]  ge_reg, ge_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic                    vneg_reg, vneg_next;
    logic                    vsat_reg, vsat_next;
    logic signed [VEL_W-1:0] va_reg, va_next;

    logic signed [VEL_W-1:0] res_left_reg, res_left_next;
    logic signed [VEL_W-1:0] res_right_reg, res_right_next;
    logic                    res_done_reg, res_done_next;
    logic                    res_moving_reg, res_moving_next;
    logic signed [DL_W-1:0]  res_dl_reg, res_dl_next;

    logic                    out_valid_reg, out_valid_next;
    logic signed [VEL_W-1:0] left_reg, left_next;
    logic signed [VEL_W-1:0] right_reg, right_next;
    logic                    spin_reg, spin_next;
    logic                    odone_reg, odone_next;
    logic [BM_W-1:0]         stop_reg, stop_next;

    // shared units
    logic                        div_start;
    logic [DIV_NUM_W-1:0]        div_num;
    logic [DIV_DEN_W-1:0]        div_den;
    logic                        div_done;
    logic [DIV_Q_W-1:0]          div_q;
    logic signed [MUL_A_W-1:0]   mul_a;
    logic signed [MUL_B_W-1:0]   mul_b;
    logic signed [MUL_P_W-1:0]   mul_p;

    // combinational helpers
    logic                      in_fire;
    logic                      out_load;
    logic signed [DIFF_W-1:0]  err_diff;
    logic signed [DIFF_W-1:0]  err_wrap;
    logic signed [DIFF_W-1:0]  err_lim;
    logic [RAMP_W-1:0]         ramp_eff;
    logic signed [TRAV_W-1:0]  trav;
    logic                      dl_lt_ramp;
    logic                      trav_lt_ramp;
    logic [RAMP_W-1:0]         spd_x;
    logic                      spd_direct;
    logic [S_W-1:0]            top_speed;
    logic [S_W-1:0]            floor_speed;
    logic [S_W-1:0]            spd_q;
    logic signed [FAC_W-1:0]   fac_a;
    logic signed [FAC_W-1:0]   fac_b;
    logic [PROD_W-1:0]         prod_abs;
    logic [S_W-1:0]            vel_mag;
    logic signed [VEL_W-1:0]   vel_pos;
    logic signed [VEL_W-1:0]   vel_val;
    logic [DL_W-1:0]           dist_d;
    logic signed [TRAV_W-1:0]  dl_new;
    logic [ENC_W-1:0]          enc_abs;

    hhdp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_q)
    );

    assign mul_p = mul_a * mul_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            td_reg   <= TD_RST;
            th_reg   <= TH_RST;
            cs_reg   <= CS_RST;
            gain_reg <= GAIN_RST;
            rev_reg  <= REV_RST;
            fs_reg   <= FS_RST;
            ramp_reg <= RAMP_RST;
            bm_reg   <= BM_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_TARGET_DISTANCE: td_reg   <= cfg_data[TD_W-1:0];
                REG_TARGET_HEADING:  th_reg   <= cfg_data[TH_W-1:0];
                REG_CRUISE_SPEED:    cs_reg   <= cfg_data[SPD_W-1:0];
                REG_STEER_GAIN:      gain_reg <= cfg_data[GAIN_W-1:0];
                REG_REVERSE:         rev_reg  <= cfg_data[0];
                REG_FINAL_SPEED:     fs_reg   <= cfg_data[SPD_W-1:0];
                REG_RAMP_LENGTH:     ramp_reg <= cfg_data[RAMP_W-1:0];
                REG_BRAKE_MODE:      bm_reg   <= cfg_data[BM_W-1:0];
            endcase
        end
    end

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    // heading error, wrapped then clamped
    always_comb
    begin
        err_diff = $signed(DIFF_W'(heading_reg)) - $signed(DIFF_W'(th_reg));
        err_wrap = err_diff;
        if (err_wrap < -ERR_WRAP_LIMIT)
        begin
            err_wrap = err_wrap + FULL_TURN;
        end
        if (err_wrap > ERR_WRAP_LIMIT)
        begin
            err_wrap = err_wrap - FULL_TURN;
        end
        err_lim = err_wrap;
        if (err_lim < -ERR_CLAMP)
        begin
            err_lim = -ERR_CLAMP;
        end
        if (err_lim > ERR_CLAMP)
        begin
            err_lim = ERR_CLAMP;
        end
    end

    // ramp selection
    always_comb
    begin
        ramp_eff     = (ramp_reg == '0) ? RAMP_W'(1) : ramp_reg;
        trav         = $signed(TRAV_W'(td_reg)) - TRAV_W'(dl_reg);
        dl_lt_ramp   = dl_reg < $signed(DL_W'(ramp_eff));
        trav_lt_ramp = trav < $signed(TRAV_W'(ramp_eff));
        spd_x        = '0;
        spd_direct   = 1'b0;
        priority if (dl_lt_ramp)
        begin
            spd_x = dl_reg[RAMP_W-1:0];
        end
        else if (trav_lt_ramp)
        begin
            spd_x = trav[TRAV_W-1] ? '0 : trav[RAMP_W-1:0];
        end
        else
        begin
            spd_direct = 1'b1;
        end
    end

    assign top_speed   = S_W'(cs_reg) * SPEED_SCALE;
    assign floor_speed = S_W'(fs_reg) * SPEED_SCALE;
    assign spd_q       = direct_reg ? top_speed : div_q;
    assign fac_a       = GAIN_SCALE - FAC_W'(ge_reg);
    assign fac_b       = GAIN_SCALE + FAC_W'(ge_reg);
    assign prod_abs    = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
    assign vel_mag     = vsat_reg ? VEL_LIMIT : div_q;
    assign vel_pos     = $signed(vel_mag);
    assign vel_val     = vneg_reg ? -vel_pos : vel_pos;
    assign dist_d      = prod_reg[DIST_SHIFT +: DL_W];
    assign dl_new      = $signed(TRAV_W'(td_reg)) - $signed(TRAV_W'(dist_d));
    assign enc_abs     = encoder_deg[ENC_W-1] ? ENC_W'(-encoder_deg) : ENC_W'(encoder_deg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (command == CMD_TICK && moving_reg)
                    begin
                        state_next = S_PREP;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_PREP:     state_next = S_SPD_GO;
            S_SPD_GO:   state_next = S_SPD_WAIT;
            S_SPD_WAIT: if (div_done) state_next = S_VA_MUL;
            S_VA_MUL:   state_next = S_VA_GO;
            S_VA_GO:    state_next = S_VA_WAIT;
            S_VA_WAIT:  if (div_done) state_next = S_VB_GO;
            S_VB_GO:    state_next = S_VB_WAIT;
            S_VB_WAIT:  if (div_done) state_next = S_DONE;
            S_DONE:     if (out_load) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        moving_next     = moving_reg;
        dl_next         = dl_reg;
        heading_next    = heading_reg;
        mag_next        = mag_reg;
        err_next        = err_reg;
        direct_next     = direct_reg;
        s_next          = s_reg;
        ge_next         = ge_reg;
        prod_next       = prod_reg;
        vneg_next       = vneg_reg;
        vsat_next       = vsat_reg;
        va_next         = va_reg;
        res_left_next   = res_left_reg;
        res_right_next  = res_right_reg;
        res_done_next   = res_done_reg;
        res_moving_next = res_moving_reg;
        res_dl_next     = res_dl_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        left_next       = left_reg;
        right_next      = right_reg;
        spin_next       = spin_reg;
        odone_next      = odone_reg;
        stop_next       = stop_reg;
        div_start       = 1'b0;
        div_num         = prod_abs[DIV_NUM_W-1:0];
        div_den         = GAIN_SCALE_DEN;
        mul_a           = '0;
        mul_b           = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    heading_next    = heading_cdeg;
                    mag_next        = enc_abs;
                    res_left_next   = '0;
                    res_right_next  = '0;
                    res_dl_next     = dl_reg;
                    res_moving_next = moving_reg;
                    res_done_next   = 1'b1;
                    if (command == CMD_START)
                    begin
                        res_dl_next     = $signed(DL_W'(td_reg));
                        res_moving_next = (td_reg != '0);
                        res_done_next   = (td_reg == '0);
                    end
                end
            end
            S_PREP:
            begin
                err_next    = err_lim[ERR_W-1:0];
                direct_next = spd_direct;
                mul_a       = $signed(MUL_A_W'(spd_x));
                mul_b       = $signed(MUL_B_W'(top_speed));
                prod_next   = mul_p[PROD_W-1:0];
            end
            S_SPD_GO:
            begin
                div_start = 1'b1;
                div_num   = prod_reg[DIV_NUM_W-1:0];
                div_den   = ramp_eff;
                mul_a     = MUL_A_W'(err_reg);
                mul_b     = $signed(MUL_B_W'(gain_reg));
                prod_next = mul_p[PROD_W-1:0];
            end
            S_SPD_WAIT:
            begin
                ge_next = prod_reg[GE_W-1:0];
                if (div_done)
                begin
                    s_next = (spd_q < floor_speed) ? floor_speed : spd_q;
                end
            end
            S_VA_MUL:
            begin
                mul_a     = $signed(MUL_A_W'(s_reg));
                mul_b     = MUL_B_W'(fac_a);
                prod_next = mul_p[PROD_W-1:0];
            end
            S_VA_GO:
            begin
                div_start = 1'b1;
                vneg_next = prod_reg[PROD_W-1];
                vsat_next = prod_abs >= VEL_SAT_LIMIT;
                mul_a     = $signed(MUL_A_W'(s_reg));
                mul_b     = MUL_B_W'(fac_b);
                prod_next = mul_p[PROD_W-1:0];
            end
            S_VA_WAIT:
            begin
                if (div_done)
                begin
                    va_next = vel_val;
                end
            end
            S_VB_GO:
            begin
                div_start = 1'b1;
                vneg_next = prod_reg[PROD_W-1];
                vsat_next = prod_abs >= VEL_SAT_LIMIT;
                mul_a     = $signed(MUL_A_W'(mag_reg));
                mul_b     = $signed(DIST_Q10);
                prod_next = mul_p[PROD_W-1:0];
            end
            S_VB_WAIT:
            begin
                if (div_done)
                begin
                    res_left_next   = rev_reg ? vel_val : va_reg;
                    res_right_next  = rev_reg ? va_reg : vel_val;
                    res_dl_next     = dl_new[DL_W-1:0];
                    res_done_next   = (dl_new <= 0);
                    res_moving_next = !(dl_new <= 0);
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    left_next      = res_left_reg;
                    right_next     = res_right_reg;
                    spin_next      = rev_reg;
                    odone_next     = res_done_reg;
                    stop_next      = (bm_reg > BRAKE_HOLD) ? BRAKE_HOLD : bm_reg;
                    dl_next        = res_dl_reg;
                    moving_next    = res_moving_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            moving_reg    <= 1'b0;
            dl_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            moving_reg    <= moving_next;
            dl_reg        <= dl_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        heading_reg    <= heading_next;
        mag_reg        <= mag_next;
        err_reg        <= err_next;
        direct_reg     <= direct_next;
        s_reg          <= s_next;
        ge_reg         <= ge_next;
        prod_reg       <= prod_next;
        vneg_reg       <= vneg_next;
        vsat_reg       <= vsat_next;
        va_reg         <= va_next;
        res_left_reg   <= res_left_next;
        res_right_reg  <= res_right_next;
        res_done_reg   <= res_done_next;
        res_moving_reg <= res_moving_next;
        res_dl_reg     <= res_dl_next;
        left_reg       <= left_next;
        right_reg      <= right_next;
        spin_reg       <= spin_next;
        odone_reg      <= odone_next;
        stop_reg       <= stop_next;
    end

    assign out_valid      = out_valid_reg;
    assign left_velocity  = left_reg;
    assign right_velocity = right_reg;
    assign spin_reverse   = spin_reg;
    assign done_res       = odone_reg;
    assign stop_mode      = stop_reg;

    // armed only with distance still to go
    a_moving_dist: assert property (@(posedge clk) disable iff (!rst_n)
        moving_reg |-> (dl_reg > 0))
        else $error("armed with no distance left");

    // divider finishes only where the sequencer waits for it
    a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_SPD_WAIT || state_reg == S_VA_WAIT ||
                      state_reg == S_VB_WAIT))
        else $error("divider result outside a wait state");

    // velocities saturated on every beat
    a_vel_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (left_velocity <= VEL_MAX && left_velocity >= -VEL_MAX &&
                       right_velocity <= VEL_MAX && right_velocity >= -VEL_MAX))
        else $error("velocity beyond saturation limit");

endmodule
